// File: src/chie_pkg.sv
package chie_pkg;

    localparam int HASH_W     = 64;
    localparam int KEY_W      = 64;
    localparam int REF_W      = 32;
    localparam int INST_SHIFT = 56;
    localparam int INST_SEL_W = 8;
    localparam int MIN_BPI    = 8;
    localparam int IL_W       = 3;
    localparam int CFG_LOG2_W = 2;
    localparam int CFG_BPI_W  = 12;
    localparam int CFG_KB_W   = 4;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        REQ_PUT = 2'd0,
        REQ_ADD = 2'd1,
        REQ_GET = 2'd2,
        REQ_DEL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_FOUND = 2'd1,
        RES_MISS  = 2'd2,
        RES_FULL  = 2'd3
    } res_kind_t;

    typedef enum logic [1:0] {
        REG_INST_LOG2 = 2'd0,
        REG_INIT_BPI  = 2'd1,
        REG_KEY_BYTES = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_INIT_CLR,
        S_IDLE,
        S_GROW_CHK,
        S_GROW_CLR,
        S_RB_CHECK,
        S_RB_DIV,
        S_RB_WAIT,
        S_RB_HRD,
        S_RB_LINK,
        S_DIV,
        S_DIV_WAIT,
        S_HEAD_RD,
        S_DISPATCH,
        S_WALK,
        S_CMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic      init;
        logic      clr_step;
        logic      load_req;
        logic      grow;
        logic      div_start;
        logic      div_rb;
        logic      set_head;
        logic      head_rd;
        logic      rd_rowhash;
        logic      rb_link;
        logic      walk_init;
        logic      row_rd;
        logic      walk_next;
        logic      update;
        logic      insert;
        logic      del;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        req_t req_type;
        logic head_zero;
        logic row_match;
        logic full;
        logic grow_due;
        logic grow_ok;
        logic clr_last;
        logic rb_done;
        logic cur_null;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [KEY_W-1:0] key_mask(input logic [CFG_KB_W-1:0] kb);
        logic [KEY_W-1:0] m;
        m = '1;
        if (kb < 4'd8) begin
            if (kb == 4'd0) begin
                m = KEY_W'(8'hFF);
            end else begin
                m = (KEY_W'(1) << {kb, 3'b000}) - KEY_W'(1);
            end
        end
        return m;
    endfunction

endpackage

// File: src/chie_div.sv
module chie_div #(
    parameter int DIV_W = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [chie_pkg::HASH_W-1:0] dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [DIV_W-1:0]            rem
);

    localparam int CNT_W = $clog2(chie_pkg::HASH_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [chie_pkg::HASH_W-1:0] dvd_reg;
    logic [DIV_W-1:0]            rem_reg;
    logic [DIV_W:0]              trial;
    logic [DIV_W-1:0]            rem_next;

    // Restoring remainder, one dividend bit per cycle from the top down.
    always_comb begin
        trial = {rem_reg, dvd_reg[chie_pkg::HASH_W-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = DIV_W'(trial - {1'b0, divisor});
        end else begin
            rem_next = DIV_W'(trial);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(chie_pkg::HASH_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: src/chie_datapath.sv
module chie_datapath #(
    parameter int MAX_ROWS                 = 1024,
    parameter int MAX_INSTANCES            = 8,
    parameter int MAX_BUCKETS_PER_INSTANCE = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  chie_pkg::cmd_t                    cmd,
    output chie_pkg::stat_t                   stat,
    input  logic [chie_pkg::CFG_LOG2_W-1:0]   cfg_log2,
    input  logic [chie_pkg::CFG_BPI_W-1:0]    cfg_init_bpi,
    input  logic [chie_pkg::CFG_KB_W-1:0]     cfg_key_bytes,
    input  logic [chie_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [chie_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser
);

    localparam int ROW_W      = $clog2(MAX_ROWS + 1);
    localparam int RA_W       = $clog2(MAX_ROWS);
    localparam int HEAD_DEPTH = MAX_INSTANCES * MAX_BUCKETS_PER_INSTANCE;
    localparam int HA_W       = $clog2(HEAD_DEPTH);
    localparam int BPI_W      = $clog2(MAX_BUCKETS_PER_INSTANCE + 1);
    localparam int TOT_W      = $clog2(HEAD_DEPTH + 1);
    localparam int ILOG_MAX   = $clog2(MAX_INSTANCES + 1) - 1;
    localparam int KW         = chie_pkg::KEY_W;
    localparam int HW         = chie_pkg::HASH_W;
    localparam int RW         = chie_pkg::REF_W;

    // Table sizing and counts
    logic [ROW_W-1:0]         row_count_reg;
    logic [ROW_W-1:0]         elem_reg;
    logic [BPI_W-1:0]         bpi_reg;
    logic [TOT_W-1:0]         tot_reg;
    logic [chie_pkg::IL_W-1:0] il_reg;
    logic [HA_W-1:0]          clr_addr_reg;
    logic [ROW_W:0]           rb_row_reg;

    // Request and walk payload
    chie_pkg::req_t           type_reg;
    logic [KW-1:0]            key_reg;
    logic [HW-1:0]            hash_reg;
    logic [RW-1:0]            blk_reg;
    logic [RW-1:0]            off_reg;
    logic [ROW_W-1:0]         cur_row_reg;
    logic [HA_W-1:0]          head_idx_reg;
    logic [ROW_W-1:0]         head_q;
    logic [HW-1:0]            rhash_q;
    logic [KW-1:0]            rkey_q;
    logic [ROW_W-1:0]         rnext_q;
    logic [RW-1:0]            rblk_q;
    logic [RW-1:0]            roff_q;

    // Pending result and output beat
    chie_pkg::status_t        res_status_reg;
    logic [RW-1:0]            res_blk_reg;
    logic [RW-1:0]            res_off_reg;
    logic                     m_valid_reg;
    chie_pkg::status_t        m_status_reg;
    logic [RW-1:0]            m_blk_reg;
    logic [RW-1:0]            m_off_reg;

    // Memories
    logic [ROW_W-1:0] heads_mem   [HEAD_DEPTH];
    logic [HW-1:0]    hash_mem    [MAX_ROWS];
    logic [KW-1:0]    key_mem     [MAX_ROWS];
    logic [RW-1:0]    blk_mem     [MAX_ROWS];
    logic [RW-1:0]    off_mem     [MAX_ROWS];
    logic [ROW_W-1:0] next_mem    [MAX_ROWS];

    logic [BPI_W-1:0]          bpi_init;
    logic [chie_pkg::IL_W-1:0] il_init;
    logic [BPI_W:0]            bpi_dbl;
    logic [HW-1:0]             hash_sel;
    logic [chie_pkg::INST_SEL_W-1:0] inst;
    logic [HA_W-1:0]           head_idx_next;
    logic                      div_done;
    logic [BPI_W-1:0]          div_rem;
    logic [RA_W-1:0]           ins_addr;
    logic [RA_W-1:0]           cur_addr;
    logic [RA_W-1:0]           rb_addr;
    logic                      head_we;
    logic [HA_W-1:0]           head_wa;
    logic [ROW_W-1:0]          head_wd;

    always_comb begin
        if (32'(cfg_init_bpi) < chie_pkg::MIN_BPI) begin
            bpi_init = BPI_W'(chie_pkg::MIN_BPI);
        end else if (32'(cfg_init_bpi) > MAX_BUCKETS_PER_INSTANCE) begin
            bpi_init = BPI_W'(MAX_BUCKETS_PER_INSTANCE);
        end else begin
            bpi_init = BPI_W'(cfg_init_bpi);
        end
        if (32'(cfg_log2) > ILOG_MAX) begin
            il_init = chie_pkg::IL_W'(ILOG_MAX);
        end else begin
            il_init = chie_pkg::IL_W'(cfg_log2);
        end
    end

    assign bpi_dbl = {bpi_reg, 1'b0};

    chie_div #(
        .DIV_W (BPI_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (hash_sel),
        .divisor  (bpi_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign hash_sel = cmd.div_rb ? rhash_q : hash_reg;

    always_comb begin
        inst = hash_sel[chie_pkg::INST_SHIFT +: chie_pkg::INST_SEL_W]
             & chie_pkg::INST_SEL_W'((16'd1 << il_reg) - 16'd1);
        head_idx_next = HA_W'(32'(inst) * MAX_BUCKETS_PER_INSTANCE + 32'(div_rem));
    end

    assign ins_addr = RA_W'(row_count_reg);
    assign cur_addr = RA_W'(cur_row_reg - ROW_W'(1));
    assign rb_addr  = RA_W'(rb_row_reg - (ROW_W + 1)'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            elem_reg      <= '0;
            bpi_reg       <= BPI_W'(chie_pkg::MIN_BPI);
            tot_reg       <= TOT_W'(chie_pkg::MIN_BPI);
            il_reg        <= '0;
            clr_addr_reg  <= '0;
            rb_row_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.init) begin
                row_count_reg <= '0;
                elem_reg      <= '0;
                bpi_reg       <= bpi_init;
                tot_reg       <= TOT_W'(bpi_init) << il_init;
                il_reg        <= il_init;
                clr_addr_reg  <= '0;
            end else if (cmd.grow) begin
                bpi_reg      <= BPI_W'(bpi_dbl);
                tot_reg      <= TOT_W'(bpi_dbl) << il_reg;
                clr_addr_reg <= '0;
                rb_row_reg   <= (ROW_W + 1)'(1);
            end else begin
                if (cmd.clr_step) begin
                    clr_addr_reg <= clr_addr_reg + HA_W'(1);
                end
                if (cmd.rb_link) begin
                    rb_row_reg <= rb_row_reg + (ROW_W + 1)'(1);
                end
                if (cmd.insert) begin
                    row_count_reg <= row_count_reg + ROW_W'(1);
                    elem_reg      <= elem_reg + ROW_W'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            type_reg <= chie_pkg::req_t'(s_tuser);
            key_reg  <= s_tdata[KW-1:0] & chie_pkg::key_mask(cfg_key_bytes);
            hash_reg <= s_tdata[KW +: HW];
            blk_reg  <= s_tdata[KW + HW +: RW];
            off_reg  <= s_tdata[KW + HW + RW +: RW];
        end
        if (cmd.set_head) begin
            head_idx_reg <= head_idx_next;
        end
        if (cmd.walk_init) begin
            cur_row_reg <= head_q;
        end else if (cmd.walk_next) begin
            cur_row_reg <= rnext_q;
        end
        if (cmd.res_set) begin
            case (cmd.res_kind)
                chie_pkg::RES_FOUND: begin
                    res_status_reg <= chie_pkg::ST_OK;
                    res_blk_reg    <= rblk_q;
                    res_off_reg    <= roff_q;
                end
                chie_pkg::RES_MISS: begin
                    res_status_reg <= chie_pkg::ST_NOT_FOUND;
                    res_blk_reg    <= '0;
                    res_off_reg    <= '0;
                end
                chie_pkg::RES_FULL: begin
                    res_status_reg <= chie_pkg::ST_FULL;
                    res_blk_reg    <= '0;
                    res_off_reg    <= '0;
                end
                default: begin
                    res_status_reg <= chie_pkg::ST_OK;
                    res_blk_reg    <= '0;
                    res_off_reg    <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_blk_reg    <= res_blk_reg;
            m_off_reg    <= res_off_reg;
        end
    end

    // Bucket heads: one write port shared by clearing, relinking, insert and delete.
    always_comb begin
        head_we = 1'b1;
        head_wa = head_idx_reg;
        head_wd = '0;
        if (cmd.clr_step) begin
            head_wa = clr_addr_reg;
        end else if (cmd.rb_link) begin
            head_wd = ROW_W'(rb_row_reg);
        end else if (cmd.insert) begin
            head_wd = row_count_reg + ROW_W'(1);
        end else if (!cmd.del) begin
            head_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            heads_mem[head_wa] <= head_wd;
        end
        if (cmd.head_rd) begin
            head_q <= heads_mem[head_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            hash_mem[ins_addr] <= hash_reg;
        end
        if (cmd.rd_rowhash) begin
            rhash_q <= hash_mem[rb_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            key_mem[ins_addr] <= key_reg;
        end
        if (cmd.row_rd) begin
            rkey_q <= key_mem[cur_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert || cmd.update) begin
            blk_mem[cmd.insert ? ins_addr : cur_addr] <= blk_reg;
        end
        if (cmd.row_rd) begin
            rblk_q <= blk_mem[cur_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert || cmd.update) begin
            off_mem[cmd.insert ? ins_addr : cur_addr] <= off_reg;
        end
        if (cmd.row_rd) begin
            roff_q <= off_mem[cur_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert || cmd.rb_link) begin
            next_mem[cmd.insert ? ins_addr : rb_addr] <= head_q;
        end
        if (cmd.row_rd) begin
            rnext_q <= next_mem[cur_addr];
        end
    end

    always_comb begin
        stat.req_type  = type_reg;
        stat.head_zero = (head_q == '0);
        stat.row_match = (rkey_q == key_reg);
        stat.full      = (32'(row_count_reg) == MAX_ROWS);
        stat.grow_due  = (32'(elem_reg) >= 32'(tot_reg));
        stat.grow_ok   = (32'(bpi_dbl) <= MAX_BUCKETS_PER_INSTANCE);
        stat.clr_last  = (32'(clr_addr_reg) == HEAD_DEPTH - 1);
        stat.rb_done   = (rb_row_reg > {1'b0, row_count_reg});
        stat.cur_null  = (cur_row_reg == '0);
        stat.div_done  = div_done;
        stat.out_free  = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_off_reg, m_blk_reg};
    assign m_tuser  = m_status_reg;

    // Every stored row is counted as an element, so the two counters never part.
    a_elem_tracks_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        elem_reg == row_count_reg)
        else $error("element count differs from row count");

    a_rows_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_count_reg) <= MAX_ROWS)
        else $error("row count above store size");

    a_no_insert_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !stat.full)
        else $error("insert issued with a full row store");

    a_load_shows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not raise the output beat");

endmodule

// File: src/chie_ctrl.sv
module chie_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr,
    input  logic            in_valid,
    output logic            in_ready,
    input  chie_pkg::stat_t stat,
    output chie_pkg::cmd_t  cmd
);

    chie_pkg::state_t state_reg;
    chie_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chie_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            chie_pkg::S_INIT:     state_next = chie_pkg::S_INIT_CLR;
            chie_pkg::S_INIT_CLR: if (stat.clr_last) state_next = chie_pkg::S_IDLE;
            chie_pkg::S_IDLE:     if (in_valid) state_next = chie_pkg::S_GROW_CHK;
            chie_pkg::S_GROW_CHK: begin
                if ((stat.req_type == chie_pkg::REQ_PUT || stat.req_type == chie_pkg::REQ_ADD)
                    && stat.grow_due && stat.grow_ok) begin
                    state_next = chie_pkg::S_GROW_CLR;
                end else begin
                    state_next = chie_pkg::S_DIV;
                end
            end
            chie_pkg::S_GROW_CLR: if (stat.clr_last) state_next = chie_pkg::S_RB_CHECK;
            chie_pkg::S_RB_CHECK: begin
                state_next = stat.rb_done ? chie_pkg::S_DIV : chie_pkg::S_RB_DIV;
            end
            chie_pkg::S_RB_DIV:   state_next = chie_pkg::S_RB_WAIT;
            chie_pkg::S_RB_WAIT:  if (stat.div_done) state_next = chie_pkg::S_RB_HRD;
            chie_pkg::S_RB_HRD:   state_next = chie_pkg::S_RB_LINK;
            chie_pkg::S_RB_LINK:  state_next = chie_pkg::S_RB_CHECK;
            chie_pkg::S_DIV:      state_next = chie_pkg::S_DIV_WAIT;
            chie_pkg::S_DIV_WAIT: if (stat.div_done) state_next = chie_pkg::S_HEAD_RD;
            chie_pkg::S_HEAD_RD:  state_next = chie_pkg::S_DISPATCH;
            chie_pkg::S_DISPATCH: begin
                unique case (stat.req_type) inside
                    chie_pkg::REQ_ADD, chie_pkg::REQ_GET: state_next = chie_pkg::S_WALK;
                    default:                              state_next = chie_pkg::S_RESP;
                endcase
            end
            chie_pkg::S_WALK: begin
                state_next = stat.cur_null ? chie_pkg::S_RESP : chie_pkg::S_CMP;
            end
            chie_pkg::S_CMP: begin
                state_next = stat.row_match ? chie_pkg::S_RESP : chie_pkg::S_WALK;
            end
            chie_pkg::S_RESP:     if (stat.out_free) state_next = chie_pkg::S_IDLE;
            default:              state_next = chie_pkg::S_INIT;
        endcase
        if (cfg_wr) begin
            state_next = chie_pkg::S_INIT;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.res_kind = chie_pkg::RES_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            chie_pkg::S_INIT:     cmd.init = 1'b1;
            chie_pkg::S_INIT_CLR: cmd.clr_step = 1'b1;
            chie_pkg::S_IDLE: begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            chie_pkg::S_GROW_CHK: begin
                cmd.grow = (stat.req_type == chie_pkg::REQ_PUT
                            || stat.req_type == chie_pkg::REQ_ADD)
                           && stat.grow_due && stat.grow_ok;
            end
            chie_pkg::S_GROW_CLR: cmd.clr_step = 1'b1;
            chie_pkg::S_RB_CHECK: cmd.rd_rowhash = !stat.rb_done;
            chie_pkg::S_RB_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_rb    = 1'b1;
            end
            chie_pkg::S_RB_WAIT: begin
                cmd.div_rb   = 1'b1;
                cmd.set_head = stat.div_done;
            end
            chie_pkg::S_RB_HRD:   cmd.head_rd = 1'b1;
            chie_pkg::S_RB_LINK:  cmd.rb_link = 1'b1;
            chie_pkg::S_DIV:      cmd.div_start = 1'b1;
            chie_pkg::S_DIV_WAIT: cmd.set_head = stat.div_done;
            chie_pkg::S_HEAD_RD:  cmd.head_rd = 1'b1;
            chie_pkg::S_DISPATCH: begin
                unique case (stat.req_type) inside
                    chie_pkg::REQ_PUT: begin
                        cmd.res_set  = 1'b1;
                        cmd.insert   = !stat.full;
                        cmd.res_kind = stat.full ? chie_pkg::RES_FULL : chie_pkg::RES_OK;
                    end
                    chie_pkg::REQ_ADD, chie_pkg::REQ_GET: cmd.walk_init = 1'b1;
                    default: begin
                        cmd.res_set  = 1'b1;
                        cmd.del      = !stat.head_zero;
                        cmd.res_kind = stat.head_zero ? chie_pkg::RES_MISS : chie_pkg::RES_OK;
                    end
                endcase
            end
            chie_pkg::S_WALK: begin
                if (stat.cur_null) begin
                    // Chain end: a get misses; an add inserts, or reports a full store.
                    cmd.res_set = 1'b1;
                    if (stat.req_type == chie_pkg::REQ_GET) begin
                        cmd.res_kind = chie_pkg::RES_MISS;
                    end else if (stat.full) begin
                        cmd.res_kind = chie_pkg::RES_FULL;
                    end else begin
                        cmd.insert = 1'b1;
                    end
                end else begin
                    cmd.row_rd = 1'b1;
                end
            end
            chie_pkg::S_CMP: begin
                if (stat.row_match) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = chie_pkg::RES_FOUND;
                    cmd.update   = (stat.req_type == chie_pkg::REQ_ADD);
                end else begin
                    cmd.walk_next = 1'b1;
                end
            end
            chie_pkg::S_RESP:     cmd.out_load = stat.out_free;
            default:              cmd.init = 1'b0;
        endcase
    end

endmodule

// File: src/chained_hash_index_engine.sv
// Each request takes its bucket modulo bit-serially; a get or add then visits the
// chain row by row. One request is in flight at a time.
// A put or add that finds as many elements as buckets first doubles the buckets per
// instance (within the maximum) and rebuilds: it clears each bucket head, then
// relinks every stored row. After reset and after every configuration register
// write the bucket heads are cleared, one per cycle, before s_tready rises.
module chained_hash_index_engine #(
    parameter int MAX_ROWS                 = 1024,
    parameter int MAX_INSTANCES            = 8,
    parameter int MAX_BUCKETS_PER_INSTANCE = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_value[63:0], hash_value[127:64], ref_block[159:128], ref_offset[191:160]
    input  logic [chie_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // old_block[31:0], old_offset[63:32]
    output logic [chie_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [1:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chie_pkg::APB_AW-1:0]       paddr,
    input  logic [chie_pkg::APB_DW-1:0]       pwdata,
    output logic [chie_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [chie_pkg::CFG_LOG2_W-1:0] log2_reg;
    logic [chie_pkg::CFG_BPI_W-1:0]  init_bpi_reg;
    logic [chie_pkg::CFG_KB_W-1:0]   key_bytes_reg;
    logic                            wr_en;
    logic                            cfg_wr;
    chie_pkg::reg_idx_t              reg_idx;
    chie_pkg::cmd_t                  cmd;
    chie_pkg::stat_t                 stat;

    assign pready  = 1'b1;
    assign reg_idx = chie_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_wr = 1'b0;
        prdata = '0;
        unique case (reg_idx)
            chie_pkg::REG_INST_LOG2: begin
                cfg_wr = wr_en;
                prdata = chie_pkg::APB_DW'(log2_reg);
            end
            chie_pkg::REG_INIT_BPI: begin
                cfg_wr = wr_en;
                prdata = chie_pkg::APB_DW'(init_bpi_reg);
            end
            chie_pkg::REG_KEY_BYTES: begin
                cfg_wr = wr_en;
                prdata = chie_pkg::APB_DW'(key_bytes_reg);
            end
            default: begin
                cfg_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg      <= '0;
            init_bpi_reg  <= chie_pkg::CFG_BPI_W'(chie_pkg::MIN_BPI);
            key_bytes_reg <= chie_pkg::CFG_KB_W'(8);
        end else if (wr_en) begin
            case (reg_idx)
                chie_pkg::REG_INST_LOG2: log2_reg      <= pwdata[chie_pkg::CFG_LOG2_W-1:0];
                chie_pkg::REG_INIT_BPI:  init_bpi_reg  <= pwdata[chie_pkg::CFG_BPI_W-1:0];
                chie_pkg::REG_KEY_BYTES: key_bytes_reg <= pwdata[chie_pkg::CFG_KB_W-1:0];
                default:                 log2_reg      <= log2_reg;
            endcase
        end
    end

    chie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chie_datapath #(
        .MAX_ROWS                 (MAX_ROWS),
        .MAX_INSTANCES            (MAX_INSTANCES),
        .MAX_BUCKETS_PER_INSTANCE (MAX_BUCKETS_PER_INSTANCE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_log2      (log2_reg),
        .cfg_init_bpi  (init_bpi_reg),
        .cfg_key_bytes (key_bytes_reg),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
